/* rtl/bcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_pkg: shared definitions for the Bezier curve flattener
// Widths, command codes, sequencer states and the structs that pass
// between the engine, the divider and the top level.
// ----------------------------------------------------------------------------
package bcf_pkg;

   // Coordinate and count geometry
   localparam int COORD_W      = 32;                              // Q16.16 coordinate
   localparam int MAX_SEGMENTS = 64;
   localparam int CNT_W        = 7;                               // segment count field
   localparam int N_CTRL       = 8;                               // p0_x .. p3_y
   localparam int W_W          = $clog2(MAX_SEGMENTS ** 3 + 1);   // Bernstein weight
   localparam int SQ_W         = $clog2(MAX_SEGMENTS ** 2 + 1);   // m^2, k^2
   localparam int ACC_W        = COORD_W + W_W + 1;               // weighted sum
   localparam int NUM_W        = ACC_W + 1;                       // divider dividend
   localparam int DEN_W        = W_W + 1;                         // divider divisor 2*n^3
   localparam int STEP_W       = $clog2(COORD_W);                 // quotient bit counter
   localparam int IDX_W        = 3;                               // product index 0..4
   localparam int ACC_STEPS    = 4;                               // control points per axis

   // Stream widths, padded to whole bytes
   localparam int IN_DATA_W  = ((N_CTRL * COORD_W + CNT_W + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((2 * COORD_W + 7) / 8) * 8;

   // Curve kind codes
   localparam logic CMD_CUBIC = 1'b0;
   localparam logic CMD_QUAD  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CUBE0,
      ST_CUBE1,
      ST_CUBE2,
      ST_W0,
      ST_W1,
      ST_W2,
      ST_W3,
      ST_W4,
      ST_W5,
      ST_W6,
      ST_ACC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } bcf_state_type;

   typedef struct packed {
      logic                            kind;
      logic [CNT_W-1:0]                count;
      logic [N_CTRL-1:0][COORD_W-1:0]  ctrl;
   } bcf_curve_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } bcf_point_type;

   typedef struct packed {
      logic idle;
      logic push;
   } bcf_eng_stat_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } bcf_div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quot;
   } bcf_div_rsp_type;

   // Zero means one point, large counts clamp to the maximum
   function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      r = c;
      if (c == '0) begin
         r = CNT_W'(1);
      end else if (int'(c) > MAX_SEGMENTS) begin
         r = CNT_W'(MAX_SEGMENTS);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/bcf_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_divider: iterative restoring divider
// Produces one quotient bit per cycle. The dividend is pre-biased so the
// unsigned quotient is the signed result with its top bit inverted.
// ----------------------------------------------------------------------------
module bcf_divider (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bcf_pkg::bcf_div_req_type req,
   output bcf_pkg::bcf_div_rsp_type      rsp
);
   import bcf_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    dsh_ff, dsh_in;
   logic [COORD_W-1:0]  quot_ff, quot_in;
   logic [NUM_W:0]      diff;
   logic                fits;
   logic [NUM_W-1:0]    den_x;

   // trial subtract of the shifted divisor
   assign diff  = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign fits  = ~diff[NUM_W];
   assign den_x = {{(NUM_W-DEN_W){1'b0}}, req.denom};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (!busy_ff && req.start) begin
         busy_in = 1'b1;
         rem_in  = req.numer;
         dsh_in  = den_x << (COORD_W - 1);
         step_in = STEP_W'(COORD_W - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[NUM_W-1:0];
         end
         quot_in = {quot_ff[COORD_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   // remove the 2^31 bias
   assign rsp.done = done_ff;
   assign rsp.quot = {~quot_ff[COORD_W-1], quot_ff[COORD_W-2:0]};

endmodule
`default_nettype wire

/* rtl/bcf_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_engine: curve sequencer with one shared multiplier
// Holds the curve, forms n^3 and the Bernstein weights for each k, sums the
// weighted controls per axis and hands each sum to the divider.
// ----------------------------------------------------------------------------
module bcf_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire bcf_pkg::bcf_curve_type   curve,
   input  wire logic                     out_free,
   output bcf_pkg::bcf_eng_stat_type     stat,
   output bcf_pkg::bcf_point_type        point,
   output bcf_pkg::bcf_div_req_type      div_req,
   input  wire bcf_pkg::bcf_div_rsp_type div_rsp
);
   import bcf_pkg::*;

   bcf_state_type        state_ff, state_in;
   bcf_curve_type        curve_ff, curve_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 axis_ff, axis_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [SQ_W-1:0]      sq_m_ff, sq_m_in;
   logic [SQ_W-1:0]      sq_k_ff, sq_k_in;
   logic [W_W-1:0]       m3_ff, m3_in;
   logic [W_W-1:0]       m2k_ff, m2k_in;
   logic [W_W-1:0]       mk2_ff, mk2_in;
   logic [W_W-1:0]       k3_ff, k3_in;
   logic [W_W-1:0]       n3_ff, n3_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   y_ff, y_in;

   logic [CNT_W-1:0]     m;
   logic                 last_pt;
   logic [W_W-1:0]       mul_a;
   logic [COORD_W-1:0]   mul_b;
   logic signed [ACC_W-1:0] mul_a_x, mul_b_x;
   logic [W_W+1:0]       m3_x, m2k_x, mk2_x;
   logic [W_W+1:0]       t1, t2;
   logic [3:0][W_W-1:0]  wt;
   logic [NUM_W-1:0]     acc_x, n3_x, numer;

   assign m       = curve_ff.count - k_ff;
   assign last_pt = (k_ff == curve_ff.count);

   // shared multiplier, unsigned weight times signed coordinate
   assign mul_a_x = {{(ACC_W-W_W){1'b0}}, mul_a};
   assign mul_b_x = {{(ACC_W-COORD_W){mul_b[COORD_W-1]}}, mul_b};
   assign prod_in = mul_a_x * mul_b_x;

   // Bernstein weights; a quadratic is elevated to a cubic exactly
   assign m3_x  = {2'b00, m3_ff};
   assign m2k_x = {2'b00, m2k_ff};
   assign mk2_x = {2'b00, mk2_ff};

   always_comb begin
      if (curve_ff.kind == CMD_CUBIC) begin
         t1    = m2k_x + (m2k_x << 1);
         t2    = mk2_x + (mk2_x << 1);
         wt[0] = m3_ff;
         wt[1] = t1[W_W-1:0];
         wt[2] = t2[W_W-1:0];
         wt[3] = k3_ff;
      end else begin
         t1    = m3_x + m2k_x;
         t2    = (m2k_x + mk2_x) << 1;
         wt[0] = t1[W_W-1:0];
         wt[1] = t2[W_W-1:0];
         wt[2] = mk2_ff + k3_ff;
         wt[3] = '0;
      end
   end

   // dividend 2*sum + n^3, biased by 2*n^3 * 2^31 to stay positive
   assign acc_x = {acc_ff[ACC_W-1], acc_ff};
   assign n3_x  = {{(NUM_W-W_W){1'b0}}, n3_ff};
   assign numer = {acc_x[NUM_W-2:0], 1'b0} + n3_x + (n3_x << COORD_W);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (load) state_in = ST_CUBE0;
         ST_CUBE0:    state_in = ST_CUBE1;
         ST_CUBE1:    state_in = ST_CUBE2;
         ST_CUBE2:    state_in = ST_W0;
         ST_W0:       state_in = ST_W1;
         ST_W1:       state_in = ST_W2;
         ST_W2:       state_in = ST_W3;
         ST_W3:       state_in = ST_W4;
         ST_W4:       state_in = ST_W5;
         ST_W5:       state_in = ST_W6;
         ST_W6:       state_in = ST_ACC;
         ST_ACC: begin
            if (idx_ff == IDX_W'(ACC_STEPS)) state_in = ST_DIV_GO;
         end
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) state_in = axis_ff ? ST_OUT : ST_ACC;
         end
         ST_OUT: begin
            if (out_free) state_in = last_pt ? ST_IDLE : ST_W0;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath control and outputs
   always_comb begin
      curve_in = curve_ff;
      k_in     = k_ff;
      idx_in   = idx_ff;
      axis_in  = axis_ff;
      acc_in   = acc_ff;
      sq_m_in  = sq_m_ff;
      sq_k_in  = sq_k_ff;
      m3_in    = m3_ff;
      m2k_in   = m2k_ff;
      mk2_in   = mk2_ff;
      k3_in    = k3_ff;
      n3_in    = n3_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      mul_a    = '0;
      mul_b    = '0;
      stat     = '{idle: (state_ff == ST_IDLE), push: 1'b0};
      div_req  = '{start: 1'b0, numer: numer, denom: {n3_ff, 1'b0}};
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               curve_in = curve;
               k_in     = CNT_W'(1);
               idx_in   = '0;
               axis_in  = 1'b0;
            end
         end
         ST_CUBE0: begin
            mul_a = W_W'(curve_ff.count);
            mul_b = COORD_W'(curve_ff.count);
         end
         ST_CUBE1: begin
            mul_a = prod_ff[W_W-1:0];
            mul_b = COORD_W'(curve_ff.count);
         end
         ST_CUBE2: begin
            n3_in = prod_ff[W_W-1:0];
         end
         ST_W0: begin
            mul_a = W_W'(m);
            mul_b = COORD_W'(m);
         end
         ST_W1: begin
            sq_m_in = prod_ff[SQ_W-1:0];
            mul_a   = W_W'(k_ff);
            mul_b   = COORD_W'(k_ff);
         end
         ST_W2: begin
            sq_k_in = prod_ff[SQ_W-1:0];
            mul_a   = W_W'(sq_m_ff);
            mul_b   = COORD_W'(m);
         end
         ST_W3: begin
            m3_in = prod_ff[W_W-1:0];
            mul_a = W_W'(sq_m_ff);
            mul_b = COORD_W'(k_ff);
         end
         ST_W4: begin
            m2k_in = prod_ff[W_W-1:0];
            mul_a  = W_W'(sq_k_ff);
            mul_b  = COORD_W'(m);
         end
         ST_W5: begin
            mk2_in = prod_ff[W_W-1:0];
            mul_a  = W_W'(sq_k_ff);
            mul_b  = COORD_W'(k_ff);
         end
         ST_W6: begin
            k3_in  = prod_ff[W_W-1:0];
            idx_in = '0;
         end
         ST_ACC: begin
            // issue product idx, fold in product idx-1
            mul_a = wt[idx_ff[1:0]];
            mul_b = curve_ff.ctrl[{idx_ff[1:0], axis_ff}];
            if (idx_ff == '0) begin
               acc_in = '0;
            end else begin
               acc_in = acc_ff + prod_ff;
            end
            if (idx_ff == IDX_W'(ACC_STEPS)) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DIV_GO: begin
            div_req.start = 1'b1;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (!axis_ff) begin
                  x_in    = div_rsp.quot;
                  axis_in = 1'b1;
               end else begin
                  y_in = div_rsp.quot;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               stat.push = 1'b1;
               axis_in   = 1'b0;
               k_in      = k_ff + CNT_W'(1);
            end
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign point = '{x: x_ff, y: y_ff, last: last_pt};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         idx_ff   <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         idx_ff   <= idx_in;
         axis_ff  <= axis_in;
      end
      curve_ff <= curve_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      sq_m_ff  <= sq_m_in;
      sq_k_ff  <= sq_k_in;
      m3_ff    <= m3_in;
      m2k_ff   <= m2k_in;
      mk2_ff   <= mk2_in;
      k3_ff    <= k3_in;
      n3_ff    <= n3_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
   end

endmodule
`default_nettype wire

/* rtl/bezier_curve_flattener_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_curve_flattener_top: uniform subdivision of cubic/quadratic curves
// One curve per request transaction, n point transactions out, the last one
// flagged on tlast. Coordinates are signed Q16.16, exactly rounded.
//
//   channel | direction | data                                 | side info
//   req     | in        | p0_x..p3_y, segment_count            | tuser: command
//   rsp     | out       | out_x, out_y                         | tlast: last
//
// A curve occupies the block from acceptance until its last point is pushed,
// n being the clamped segment count (1 to 64). Each point costs six weight
// multiplies and four products per axis on the one multiplier plus one
// division per axis in the bit-serial divider. req_tready is high only
// between curves.
// Reset is synchronous; a point waiting in the output register holds while
// rsp_tready is low, and the sequencer stalls until that register frees up.
// ----------------------------------------------------------------------------
module bezier_curve_flattener_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, segment_count, zero pad
   input  wire logic [bcf_pkg::IN_DATA_W-1:0]     req_tdata,
   // command
   input  wire logic [0:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_x, out_y
   output logic [bcf_pkg::OUT_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast
);
   import bcf_pkg::*;

   bcf_curve_type     curve;
   bcf_eng_stat_type  stat;
   bcf_point_type     point;
   bcf_div_req_type   div_req;
   bcf_div_rsp_type   div_rsp;
   logic              req_accept;
   logic              out_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic               rsp_last_ff, rsp_last_in;

   assign req_tready = stat.idle;
   assign req_accept = req_tvalid && req_tready;

   // unpack the request transaction
   always_comb begin
      curve.kind  = req_tuser[0];
      curve.count = sat_count(req_tdata[N_CTRL*COORD_W +: CNT_W]);
      for (int i = 0; i < N_CTRL; i++) begin
         curve.ctrl[i] = req_tdata[i*COORD_W +: COORD_W];
      end
   end

   bcf_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .curve    (curve),
      .out_free (out_free),
      .stat     (stat),
      .point    (point),
      .div_req  (div_req),
      .div_rsp  (div_rsp)
   );

   bcf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = out_free ? stat.push : rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      if (stat.push) begin
         rsp_x_in    = point.x;
         rsp_y_in    = point.y;
         rsp_last_in = point.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DATA_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
